[src/multibrot_escape_time_unit_assert.svh]
// Assertion macros of the escape-time unit, used by the controller module.
// Each macro expects signals named clk and rst in the including scope.
`ifndef MULTIBROT_ESCAPE_TIME_UNIT_ASSERT_SVH
`define MULTIBROT_ESCAPE_TIME_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MBE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/mbe_pkg.sv]
// Shared types, constants and the micro-program table of the escape-time unit.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package mbe_pkg;

  localparam int FRAC_BITS_DEF  = 28;
  localparam int COUNT_BITS_DEF = 16;
  localparam int DATA_W         = 32;
  localparam int ACC_W          = 37;
  localparam int CLIP_SH        = 33;
  localparam int ITER_W         = 16;
  localparam int DEG_W          = 3;
  localparam int PC_W           = 4;
  localparam int CFG_IDX_W      = 1;

  localparam logic [ITER_W-1:0]    MAX_ITER_RESET = ITER_W'(256);
  localparam logic [DEG_W-1:0]     DEGREE_RESET   = DEG_W'(2);
  localparam logic [1:0]           EXTRA_ITERS    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_RUN, S_WAIT, S_DECIDE, S_DONE
  } state_t;

  typedef enum logic [1:0] {PRG_INT, PRG_D2, PRG_D3, PRG_D4} prog_t;

  typedef enum logic [3:0] {
    SRC_ZR, SRC_ZI, SRC_CI, SRC_T, SRC_T2, SRC_R2, SRC_I2, SRC_U, SRC_V, SRC_Q, SRC_RQ
  } src_t;

  typedef enum logic [2:0] {
    DST_NONE, DST_R2, DST_I2, DST_U, DST_V, DST_Q, DST_CARD, DST_BULB
  } dst_t;

  typedef enum logic [1:0] {ACC_NONE, ACC_RE, ACC_IM} acc_t;

  typedef enum logic [2:0] {CF_P1, CF_M1, CF_P2, CF_P3, CF_M3, CF_P4, CF_M4, CF_M6} coef_t;

  typedef struct packed {
    src_t  a;
    src_t  b;
    dst_t  dst;
    acc_t  acc;
    coef_t coef;
    logic  commit;
    logic  last;
  } uop_t;

  typedef struct packed {
    logic load;
    logic out_load;
    uop_t op;
  } cmd_t;

  typedef struct packed {
    logic mag_gt;
    logic inner;
  } stat_t;

  localparam uop_t UOP_NOP = '{a: SRC_ZR, b: SRC_ZR, dst: DST_NONE, acc: ACC_NONE,
                               coef: CF_P1, commit: 1'b0, last: 1'b0};

  function automatic uop_t mk_uop(src_t sa, src_t sb, dst_t sd, acc_t sc, coef_t cf,
                                  logic cm, logic lst);
    return '{a: sa, b: sb, dst: sd, acc: sc, coef: cf, commit: cm, last: lst};
  endfunction

  // One multiply is issued per entry; a result may be read two entries later.
  function automatic uop_t uop_fetch(prog_t p, logic [PC_W-1:0] pc);
    uop_t u;
    u = mk_uop(SRC_ZR, SRC_ZR, DST_NONE, ACC_NONE, CF_P1, 1'b0, 1'b1);
    unique case (p)
      PRG_INT: begin
        case (pc)
          4'd0: u = mk_uop(SRC_CI, SRC_CI, DST_I2, ACC_NONE, CF_P1, 1'b0, 1'b0);
          4'd1: u = UOP_NOP;
          4'd2: u = mk_uop(SRC_T, SRC_T, DST_Q, ACC_NONE, CF_P1, 1'b0, 1'b0);
          4'd3: u = mk_uop(SRC_T2, SRC_T2, DST_BULB, ACC_NONE, CF_P1, 1'b0, 1'b0);
          4'd4: u = mk_uop(SRC_Q, SRC_RQ, DST_CARD, ACC_NONE, CF_P1, 1'b0, 1'b1);
          default: ;
        endcase
      end
      PRG_D2: begin
        case (pc)
          4'd0: u = mk_uop(SRC_ZR, SRC_ZR, DST_R2, ACC_RE, CF_P1, 1'b0, 1'b0);
          4'd1: u = mk_uop(SRC_ZI, SRC_ZI, DST_I2, ACC_RE, CF_M1, 1'b0, 1'b0);
          4'd2: u = mk_uop(SRC_ZR, SRC_ZI, DST_NONE, ACC_IM, CF_P2, 1'b0, 1'b0);
          4'd3: u = mk_uop(SRC_ZR, SRC_ZR, DST_NONE, ACC_NONE, CF_P1, 1'b1, 1'b1);
          default: ;
        endcase
      end
      PRG_D3: begin
        case (pc)
          4'd0: u = mk_uop(SRC_ZR, SRC_ZR, DST_R2, ACC_NONE, CF_P1, 1'b0, 1'b0);
          4'd1: u = mk_uop(SRC_ZI, SRC_ZI, DST_I2, ACC_NONE, CF_P1, 1'b0, 1'b0);
          4'd2: u = mk_uop(SRC_ZR, SRC_R2, DST_NONE, ACC_RE, CF_P1, 1'b0, 1'b0);
          4'd3: u = mk_uop(SRC_ZI, SRC_R2, DST_NONE, ACC_IM, CF_P3, 1'b0, 1'b0);
          4'd4: u = mk_uop(SRC_ZR, SRC_I2, DST_NONE, ACC_RE, CF_M3, 1'b0, 1'b0);
          4'd5: u = mk_uop(SRC_ZI, SRC_I2, DST_NONE, ACC_IM, CF_M1, 1'b0, 1'b0);
          4'd6: u = mk_uop(SRC_ZR, SRC_ZR, DST_NONE, ACC_NONE, CF_P1, 1'b1, 1'b1);
          default: ;
        endcase
      end
      PRG_D4: begin
        case (pc)
          4'd0: u = mk_uop(SRC_ZR, SRC_ZR, DST_R2, ACC_NONE, CF_P1, 1'b0, 1'b0);
          4'd1: u = mk_uop(SRC_ZI, SRC_ZI, DST_I2, ACC_NONE, CF_P1, 1'b0, 1'b0);
          4'd2: u = mk_uop(SRC_R2, SRC_ZR, DST_U, ACC_NONE, CF_P1, 1'b0, 1'b0);
          4'd3: u = mk_uop(SRC_ZR, SRC_I2, DST_V, ACC_NONE, CF_P1, 1'b0, 1'b0);
          4'd4: u = mk_uop(SRC_U, SRC_ZI, DST_NONE, ACC_IM, CF_P4, 1'b0, 1'b0);
          4'd5: u = mk_uop(SRC_V, SRC_ZI, DST_NONE, ACC_IM, CF_M4, 1'b0, 1'b0);
          4'd6: u = mk_uop(SRC_R2, SRC_R2, DST_NONE, ACC_RE, CF_P1, 1'b0, 1'b0);
          4'd7: u = mk_uop(SRC_R2, SRC_I2, DST_NONE, ACC_RE, CF_M6, 1'b0, 1'b0);
          4'd8: u = mk_uop(SRC_I2, SRC_I2, DST_NONE, ACC_RE, CF_P1, 1'b0, 1'b0);
          4'd9: u = mk_uop(SRC_ZR, SRC_ZR, DST_NONE, ACC_NONE, CF_P1, 1'b1, 1'b1);
          default: ;
        endcase
      end
      default: ;
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

[src/mbe_ctrl.sv]
// Controller of the escape-time unit: sequencer state machine, iteration count,
// escape bookkeeping and the output handshake. Depends on mbe_pkg and the assert header.
`default_nettype none
`include "multibrot_escape_time_unit_assert.svh"

module mbe_ctrl import mbe_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  logic [ITER_W-1:0]   max_iterations,
  input  logic [DEG_W-1:0]    degree,
  input  stat_t               stat,
  output cmd_t                cmd,
  output logic [COUNT_BITS:0] iteration_count,
  output logic                escaped,
  output logic                interior
);

  state_t                state, state_next;
  prog_t                 prog, prog_next;
  prog_t                 iter_prog, iter_prog_next;
  prog_t                 deg_prog;
  logic [PC_W-1:0]       pc, pc_next;
  logic [COUNT_BITS:0]   count, count_next;
  logic [1:0]            extra, extra_next;
  logic                  esc_f, esc_next;
  logic                  inner_f, inner_next;
  logic                  out_valid_next;
  logic [COUNT_BITS+ITER_W-1:0] limit_wide;
  logic [COUNT_BITS-1:0] limit;

  // Only the low COUNT_BITS bits of the limit register take part.
  assign limit_wide = {{COUNT_BITS{1'b0}}, max_iterations};
  assign limit      = limit_wide[COUNT_BITS-1:0];

  always_comb begin
    unique case (degree) inside
      [3'd0:3'd2]: deg_prog = PRG_D2;
      3'd3:        deg_prog = PRG_D3;
      default:     deg_prog = PRG_D4;
    endcase
  end

  always_comb begin
    state_next     = state;
    prog_next      = prog;
    iter_prog_next = iter_prog;
    pc_next        = pc;
    count_next     = count;
    extra_next     = extra;
    esc_next       = esc_f;
    inner_next     = inner_f;
    out_valid_next = out_valid && out_stall;
    in_stall       = 1'b1;
    cmd.load       = 1'b0;
    cmd.out_load   = 1'b0;
    cmd.op         = UOP_NOP;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load       = 1'b1;
          count_next     = (COUNT_BITS+1)'(1);
          esc_next       = 1'b0;
          inner_next     = 1'b0;
          extra_next     = 2'd0;
          pc_next        = '0;
          iter_prog_next = deg_prog;
          if (deg_prog == PRG_D2) begin
            prog_next  = PRG_INT;
            state_next = S_RUN;
          end else begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (count >= {1'b0, limit}) begin
          state_next = S_DONE;
        end else begin
          prog_next  = iter_prog;
          pc_next    = '0;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        cmd.op  = uop_fetch(prog, pc);
        pc_next = pc + 1'b1;
        if (cmd.op.last) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (prog == PRG_INT) begin
          if (stat.inner) begin
            inner_next = 1'b1;
            count_next = '0;
            state_next = S_DONE;
          end else begin
            state_next = S_CHECK;
          end
        end else if (extra != 2'd0) begin
          extra_next = extra - 1'b1;
          if (extra == 2'd1) begin
            state_next = S_DONE;
          end else begin
            pc_next    = '0;
            state_next = S_RUN;
          end
        end else if (stat.mag_gt) begin
          // The squares still held belong to the z that entered this step.
          esc_next   = 1'b1;
          extra_next = EXTRA_ITERS;
          count_next = count + (COUNT_BITS+1)'(EXTRA_ITERS);
          pc_next    = '0;
          state_next = S_RUN;
        end else begin
          count_next = count + 1'b1;
          state_next = S_CHECK;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      prog      <= PRG_INT;
      iter_prog <= PRG_D2;
      pc        <= '0;
      count     <= '0;
      extra     <= 2'd0;
      esc_f     <= 1'b0;
      inner_f   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      prog      <= prog_next;
      iter_prog <= iter_prog_next;
      pc        <= pc_next;
      count     <= count_next;
      extra     <= extra_next;
      esc_f     <= esc_next;
      inner_f   <= inner_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      iteration_count <= count;
      escaped         <= esc_f;
      interior        <= inner_f;
    end
  end

  `MBE_ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall, state != S_IDLE, "accepted word did not start work")
  `MBE_ASSERT_IMPL(a_flags_exclusive, state == S_DONE, !(esc_f && inner_f), "escape and interior both set")
  `MBE_ASSERT_IMPL(a_interior_deg2, state == S_DONE && inner_f, iter_prog == PRG_D2, "interior flagged off degree two")
  `MBE_ASSERT_IMPL(a_count_bound, state != S_IDLE, count <= limit + 1'b1, "iteration count ran past the limit")

endmodule

`default_nettype wire

[src/mbe_dpath.sv]
// Datapath of the escape-time unit: one shared 32x32 multiplier, scaling and
// saturation, accumulators and the z, c and temporary registers. Depends on mbe_pkg.
`default_nettype none

module mbe_dpath import mbe_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  input  logic signed [DATA_W-1:0] c_re,
  input  logic signed [DATA_W-1:0] c_im,
  output stat_t                    stat,
  output logic signed [DATA_W-1:0] final_re,
  output logic signed [DATA_W-1:0] final_im
);

  // Constants beyond the reach of any 32-bit value are clipped; every use stays exact.
  localparam int SH_ONE  = (FRAC_BITS > CLIP_SH) ? CLIP_SH : FRAC_BITS;
  localparam int SH_QTR  = (FRAC_BITS - 2 > CLIP_SH) ? CLIP_SH : FRAC_BITS - 2;
  localparam int SH_SIX  = (FRAC_BITS - 4 > CLIP_SH) ? CLIP_SH : FRAC_BITS - 4;
  localparam int SH_FOUR = (FRAC_BITS + 2 > CLIP_SH) ? CLIP_SH : FRAC_BITS + 2;
  localparam logic signed [ACC_W-1:0] K_ONE  = ACC_W'(64'd1 << SH_ONE);
  localparam logic signed [ACC_W-1:0] K_QTR  = ACC_W'(64'd1 << SH_QTR);
  localparam logic signed [ACC_W-1:0] K_SIX  = ACC_W'(64'd1 << SH_SIX);
  localparam logic signed [ACC_W-1:0] K_FOUR = ACC_W'(64'd1 << SH_FOUR);

  function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
    if (v[ACC_W-1:DATA_W-1] == '0 || v[ACC_W-1:DATA_W-1] == '1) begin
      return $signed(v[DATA_W-1:0]);
    end else if (v[ACC_W-1]) begin
      return $signed({1'b1, {(DATA_W-1){1'b0}}});
    end else begin
      return $signed({1'b0, {(DATA_W-1){1'b1}}});
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_prod(
    input logic signed [2*DATA_W-1:0] v
  );
    if (v[2*DATA_W-1:DATA_W-1] == '0 || v[2*DATA_W-1:DATA_W-1] == '1) begin
      return $signed(v[DATA_W-1:0]);
    end else if (v[2*DATA_W-1]) begin
      return $signed({1'b1, {(DATA_W-1){1'b0}}});
    end else begin
      return $signed({1'b0, {(DATA_W-1){1'b1}}});
    end
  endfunction

  logic signed [DATA_W-1:0]   zr, zi, cr, ci, tq, t2, r2, i2, u, v, q;
  logic signed [ACC_W-1:0]    acc_re, acc_im;
  logic signed [2*DATA_W-1:0] prod, prod_sh;
  uop_t                       wb_op;
  logic                       inner;
  logic signed [DATA_W-1:0]   op_a, op_b, f, rq;
  logic signed [ACC_W-1:0]    f_ext, i2_ext, scaled, mag, fi_sum;

  assign rq      = sat_acc(ACC_W'(q) + ACC_W'(tq));
  assign prod_sh = prod >>> FRAC_BITS;
  assign f       = sat_prod(prod_sh);
  assign f_ext   = ACC_W'(f);
  assign i2_ext  = ACC_W'(i2);
  assign fi_sum  = f_ext + i2_ext;
  assign mag     = ACC_W'(r2) + i2_ext;

  assign stat.mag_gt = mag > K_FOUR;
  assign stat.inner  = inner;

  always_comb begin
    case (cmd.op.a)
      SRC_ZR:  op_a = zr;
      SRC_ZI:  op_a = zi;
      SRC_CI:  op_a = ci;
      SRC_T:   op_a = tq;
      SRC_T2:  op_a = t2;
      SRC_R2:  op_a = r2;
      SRC_I2:  op_a = i2;
      SRC_U:   op_a = u;
      SRC_V:   op_a = v;
      SRC_Q:   op_a = q;
      SRC_RQ:  op_a = rq;
      default: op_a = zr;
    endcase
  end

  always_comb begin
    case (cmd.op.b)
      SRC_ZR:  op_b = zr;
      SRC_ZI:  op_b = zi;
      SRC_CI:  op_b = ci;
      SRC_T:   op_b = tq;
      SRC_T2:  op_b = t2;
      SRC_R2:  op_b = r2;
      SRC_I2:  op_b = i2;
      SRC_U:   op_b = u;
      SRC_V:   op_b = v;
      SRC_Q:   op_b = q;
      SRC_RQ:  op_b = rq;
      default: op_b = zr;
    endcase
  end

  always_comb begin
    case (wb_op.coef)
      CF_P1:   scaled = f_ext;
      CF_M1:   scaled = -f_ext;
      CF_P2:   scaled = f_ext <<< 1;
      CF_P3:   scaled = f_ext + (f_ext <<< 1);
      CF_M3:   scaled = -(f_ext + (f_ext <<< 1));
      CF_P4:   scaled = f_ext <<< 2;
      CF_M4:   scaled = -(f_ext <<< 2);
      CF_M6:   scaled = -((f_ext <<< 2) + (f_ext <<< 1));
      default: scaled = f_ext;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_op <= UOP_NOP;
    end else begin
      wb_op <= cmd.op;
    end
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (cmd.load) begin
      zr     <= c_re;
      zi     <= c_im;
      cr     <= c_re;
      ci     <= c_im;
      acc_re <= ACC_W'(c_re);
      acc_im <= ACC_W'(c_im);
      tq     <= sat_acc(ACC_W'(c_re) - K_QTR);
      t2     <= sat_acc(ACC_W'(c_re) + K_ONE);
      inner  <= 1'b0;
    end else begin
      case (wb_op.dst)
        DST_R2:   r2 <= f;
        DST_I2:   i2 <= f;
        DST_U:    u  <= f;
        DST_V:    v  <= f;
        DST_Q:    q  <= sat_acc(fi_sum);
        DST_CARD: begin
          if (f_ext < (i2_ext >>> 2)) begin
            inner <= 1'b1;
          end
        end
        DST_BULB: begin
          if (ACC_W'(sat_acc(fi_sum)) < K_SIX) begin
            inner <= 1'b1;
          end
        end
        default: ;
      endcase
      case (wb_op.acc)
        ACC_RE:  acc_re <= acc_re + scaled;
        ACC_IM:  acc_im <= acc_im + scaled;
        default: ;
      endcase
      // Commit closes a step: new z from the sums, sums restart from c.
      if (wb_op.commit) begin
        zr     <= sat_acc(acc_re);
        zi     <= sat_acc(acc_im);
        acc_re <= ACC_W'(cr);
        acc_im <= ACC_W'(ci);
      end
    end
    if (cmd.out_load) begin
      final_re <= zr;
      final_im <= zi;
    end
  end

endmodule

`default_nettype wire

[src/multibrot_escape_time_unit.sv]
// Each step of z^d + c for degree 2, 3 or 4 is a micro-program run on the shared 32x32
// multiplier; two more steps follow an escape, and degree 2 first runs an interior test.
// A word is taken only in the idle state, so each word is finished before the next is
// accepted; a new word is taken while a result waits.
// Synchronous reset: max_iterations = 256, degree = 2, no result pending.
// Top level: configuration registers and the controller/datapath pair. Depends on mbe_pkg.
`default_nettype none

module multibrot_escape_time_unit import mbe_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] c_re,
  input  logic signed [DATA_W-1:0] c_im,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [COUNT_BITS:0]      iteration_count,
  output logic                     escaped,
  output logic                     interior,
  output logic signed [DATA_W-1:0] final_re,
  output logic signed [DATA_W-1:0] final_im,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [ITER_W-1:0]        cfg_data
);

  logic [ITER_W-1:0] max_iterations;
  logic [DEG_W-1:0]  degree;
  cmd_t              cmd;
  stat_t             stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= MAX_ITER_RESET;
      degree         <= DEGREE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_ITER: max_iterations <= cfg_data;
        REG_DEGREE:   degree         <= cfg_data[DEG_W-1:0];
        default: ;
      endcase
    end
  end

  mbe_ctrl #(
    .COUNT_BITS(COUNT_BITS)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .max_iterations  (max_iterations),
    .degree          (degree),
    .stat            (stat),
    .cmd             (cmd),
    .iteration_count (iteration_count),
    .escaped         (escaped),
    .interior        (interior)
  );

  mbe_dpath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .c_re     (c_re),
    .c_im     (c_im),
    .stat     (stat),
    .final_re (final_re),
    .final_im (final_im)
  );

endmodule

`default_nettype wire

[tb/multibrot_escape_time_unit_tb.sv]
// Self-checking testbench for multibrot_escape_time_unit: a directed table, then random
// pixels over many limit and degree settings, checked against a fixed-point predictor.
// Depends on mbe_pkg and the unit's RTL only.

module multibrot_escape_time_unit_tb;
  import mbe_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int CNT_W = COUNT_BITS_DEF + 1;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 40;
  localparam int NUM_DIRECTED = 25;
  localparam int NUM_PHASES = 13;
  localparam int PIXELS_PER_PHASE = 73;

  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_ONE = 32'h1000_0000;
  localparam logic [31:0] Q_NEG_ONE = 32'hF000_0000;
  localparam logic [31:0] Q_TWO = 32'h2000_0000;
  localparam logic [31:0] Q_NEG_TWO = 32'hE000_0000;
  localparam logic [31:0] Q_THREE = 32'h3000_0000;
  localparam logic [31:0] Q_HALF = 32'h0800_0000;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic esc;
    logic inner;
    logic [31:0] zr;
    logic [31:0] zi;
  } pixel_t;

  typedef struct packed {
    logic [ITER_W-1:0] limit;
    logic [DEG_W-1:0] deg;
    logic [31:0] re;
    logic [31:0] im;
    logic known;
    logic [CNT_W-1:0] count;
    logic esc;
    logic inner;
    logic [31:0] zr;
    logic [31:0] zi;
  } row_t;

  // limit, degree, c_re, c_im, known, count, escaped, interior, final_re, final_im
  localparam row_t DIRECTED [NUM_DIRECTED] = '{
    '{16'd256, 3'd2, 32'h0, 32'h0, 1'b1, 17'd0, 1'b0, 1'b1, 32'h0, 32'h0},
    '{16'd256, 3'd2, Q_NEG_ONE, 32'h0, 1'b1, 17'd0, 1'b0, 1'b1, Q_NEG_ONE, 32'h0},
    '{16'd256, 3'd2, Q_NEG_TWO, 32'h0, 1'b1, 17'd256, 1'b0, 1'b0, Q_TWO, 32'h0},
    '{16'd256, 3'd2, Q_TWO, 32'h0, 1'b0, 17'd0, 1'b0, 1'b0, 32'h0, 32'h0},
    '{16'd256, 3'd2, 32'h0400_0000, 32'h0, 1'b0, 17'd0, 1'b0, 1'b0, 32'h0, 32'h0},
    '{16'd256, 3'd2, 32'hF400_0000, 32'h0, 1'b0, 17'd0, 1'b0, 1'b0, 32'h0, 32'h0},
    '{16'd256, 3'd2, 32'hEC00_0000, 32'h0, 1'b0, 17'd0, 1'b0, 1'b0, 32'h0, 32'h0},
    '{16'd256, 3'd2, 32'h04CC_CCCD, 32'h0, 1'b0, 17'd0, 1'b0, 1'b0, 32'h0, 32'h0},
    '{16'd256, 3'd2, 32'hFE66_6666, 32'h0A66_6666, 1'b0, 17'd0, 1'b0, 1'b0, 32'h0, 32'h0},
    '{16'd256, 3'd2, 32'hF400_0000, 32'h0199_999A, 1'b0, 17'd0, 1'b0, 1'b0, 32'h0, 32'h0},
    '{16'd256, 3'd2, Q_MAX, Q_MAX, 1'b0, 17'd0, 1'b0, 1'b0, 32'h0, 32'h0},
    '{16'd256, 3'd2, Q_MIN, Q_MIN, 1'b0, 17'd0, 1'b0, 1'b0, 32'h0, 32'h0},
    '{16'd256, 3'd2, Q_MIN, 32'h0, 1'b0, 17'd0, 1'b0, 1'b0, 32'h0, 32'h0},
    '{16'd1, 3'd2, 32'h0, 32'h0, 1'b1, 17'd0, 1'b0, 1'b1, 32'h0, 32'h0},
    '{16'd1, 3'd4, Q_THREE, 32'h0, 1'b1, 17'd1, 1'b0, 1'b0, Q_THREE, 32'h0},
    '{16'd0, 3'd3, Q_HALF, Q_HALF, 1'b1, 17'd1, 1'b0, 1'b0, Q_HALF, Q_HALF},
    '{16'd256, 3'd3, 32'h0, 32'h0, 1'b1, 17'd256, 1'b0, 1'b0, 32'h0, 32'h0},
    '{16'd256, 3'd3, Q_MAX, Q_MIN, 1'b0, 17'd0, 1'b0, 1'b0, 32'h0, 32'h0},
    '{16'd10, 3'd5, 32'h0, 32'h0, 1'b1, 17'd10, 1'b0, 1'b0, 32'h0, 32'h0},
    '{16'd10, 3'd7, Q_MIN, Q_MIN, 1'b0, 17'd0, 1'b0, 1'b0, 32'h0, 32'h0},
    '{16'd10, 3'd4, Q_MAX, Q_MAX, 1'b0, 17'd0, 1'b0, 1'b0, 32'h0, 32'h0},
    '{16'd256, 3'd1, 32'h1, 32'hFFFF_FFFF, 1'b1, 17'd0, 1'b0, 1'b1, 32'h1, 32'hFFFF_FFFF},
    '{16'd256, 3'd0, Q_NEG_ONE, 32'h0, 1'b1, 17'd0, 1'b0, 1'b1, Q_NEG_ONE, 32'h0},
    '{16'd65535, 3'd2, 32'h0, 32'h0, 1'b1, 17'd0, 1'b0, 1'b1, 32'h0, 32'h0},
    '{16'd65535, 3'd3, Q_MAX, 32'h0, 1'b0, 17'd0, 1'b0, 1'b0, 32'h0, 32'h0}
  };

  localparam logic [ITER_W-1:0] PHASE_LIMIT [NUM_PHASES] = '{
    16'd1, 16'd0, 16'd2, 16'd24, 16'd64, 16'd100, 16'd40, 16'd30, 16'd48, 16'd16,
    16'd65535, 16'd300, 16'd12
  };
  localparam logic [DEG_W-1:0] PHASE_DEG [NUM_PHASES] = '{
    3'd2, 3'd3, 3'd4, 3'd2, 3'd3, 3'd4, 3'd0, 3'd1, 3'd5, 3'd7, 3'd2, 3'd2, 3'd6
  };
  localparam logic [31:0] EDGE_VALUES [8] = '{
    Q_MAX, Q_MIN, 32'h0, 32'h1, 32'hFFFF_FFFF, Q_TWO, Q_NEG_TWO, Q_ONE
  };

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [DATA_W-1:0] c_re;
  logic signed [DATA_W-1:0] c_im;
  logic out_valid;
  logic out_stall;
  logic [CNT_W-1:0] iteration_count;
  logic escaped;
  logic interior;
  logic signed [DATA_W-1:0] final_re;
  logic signed [DATA_W-1:0] final_im;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ITER_W-1:0] cfg_data;

  logic [ITER_W-1:0] limit_setting;
  logic [DEG_W-1:0] degree_setting;
  logic calm;
  pixel_t expected_pixels[$];
  int unsigned fail_count = 0;
  int unsigned checked = 0;
  int unsigned cfg_writes = 0;

  multibrot_escape_time_unit DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .c_re(c_re),
    .c_im(c_im),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .iteration_count(iteration_count),
    .escaped(escaped),
    .interior(interior),
    .final_re(final_re),
    .final_im(final_im),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint clip32(input longint v);
    if (v > S32_HI) return S32_HI;
    if (v < S32_LO) return S32_LO;
    return v;
  endfunction

  // Product scaled back to Q4.28, rounded toward minus infinity, then clipped.
  function automatic longint qmul(input longint a, input longint b);
    longint p;
    p = a * b;
    return clip32(p >>> FRAC);
  endfunction

  // One step z <- z^d + c; mag is |z|^2 of the z that entered the step.
  function automatic void zpow_add(input int unsigned d, inout longint zr, inout longint zi,
                                   input longint cr, input longint ci, output longint mag);
    longint xr, xi, r2, i2;
    xr = zr;
    xi = zi;
    r2 = qmul(xr, xr);
    i2 = qmul(xi, xi);
    if (d == 2) begin
      zi = clip32(2 * qmul(xr, xi) + ci);
      zr = clip32(r2 - i2 + cr);
    end else if (d == 3) begin
      zr = clip32(qmul(xr, r2) - 3 * qmul(xr, i2) + cr);
      zi = clip32(3 * qmul(xi, r2) - qmul(xi, i2) + ci);
    end else begin
      zi = clip32(4 * (qmul(qmul(r2, xr), xi) - qmul(qmul(xr, i2), xi)) + ci);
      zr = clip32(qmul(r2, r2) - 6 * qmul(r2, i2) + qmul(i2, i2) + cr);
    end
    mag = r2 + i2;
  endfunction

  // Main cardioid or period-2 bulb, evaluated in the same fixed-point arithmetic.
  function automatic bit in_main_body(input longint cr, input longint ci);
    longint quarter, sixteenth, one, i2, t, q, r, t2;
    quarter = longint'(1) << (FRAC - 2);
    sixteenth = longint'(1) << (FRAC - 4);
    one = longint'(1) << FRAC;
    i2 = qmul(ci, ci);
    t = clip32(cr - quarter);
    q = clip32(qmul(t, t) + i2);
    r = clip32(q + t);
    if (qmul(q, r) < (i2 >>> 2)) return 1'b1;
    t2 = clip32(cr + one);
    return clip32(qmul(t2, t2) + i2) < sixteenth;
  endfunction

  function automatic pixel_t escape_time_of(input logic [31:0] re, input logic [31:0] im);
    pixel_t res;
    longint cr, ci, zr, zi, mag, four;
    int unsigned d, count, lim;
    logic esc, inner;
    cr = longint'($signed(re));
    ci = longint'($signed(im));
    zr = cr;
    zi = ci;
    count = 1;
    esc = 1'b0;
    inner = 1'b0;
    four = longint'(4) << FRAC;
    lim = limit_setting;
    d = (degree_setting < 3'd2) ? 2 : (degree_setting > 3'd4) ? 4 : int'(degree_setting);
    if (d == 2 && in_main_body(cr, ci)) begin
      inner = 1'b1;
      count = 0;
    end else begin
      while (count < lim) begin
        zpow_add(d, zr, zi, cr, ci, mag);
        if (mag > four) begin
          zpow_add(d, zr, zi, cr, ci, mag);
          zpow_add(d, zr, zi, cr, ci, mag);
          count += 2;
          esc = 1'b1;
          break;
        end
        count++;
      end
    end
    res.count = CNT_W'(count);
    res.esc = esc;
    res.inner = inner;
    res.zr = zr[31:0];
    res.zi = zi[31:0];
    return res;
  endfunction

  // No gap when calm or in nearly half of the draws; else mostly a short gap, now and then a long one.
  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 90);
  endfunction

  task automatic send_pixel(input logic [31:0] re, input logic [31:0] im, input pixel_t want);
    int unsigned gap;
    gap = idle_span();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    c_re <= re;
    c_im <= im;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_pixels.push_back(want);
  endtask

  task automatic drain_pixels();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  // Writes both registers back to back; upper bits of the degree word are random.
  task automatic program_unit(input logic [ITER_W-1:0] lim, input logic [DEG_W-1:0] deg);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MAX_ITER;
    cfg_data <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_DEGREE;
    cfg_data <= ITER_W'({$urandom(), deg});
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    limit_setting = lim;
    degree_setting = deg;
    cfg_writes += 2;
  endtask

  task automatic report_field(input string field, input logic [31:0] want_v,
                              input logic [31:0] got_v);
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
    fail_count++;
  endtask

  initial begin : result_backpressure
    int unsigned span;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      span = idle_span();
      if (span != 0) begin
        out_stall <= 1'b1;
        repeat (span) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(0, 6)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: result word with no pixel outstanding, count %0d", $time,
                 iteration_count);
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (iteration_count !== want.count)
          report_field("iteration_count", want.count, iteration_count);
        if (escaped !== want.esc) report_field("escaped", want.esc, escaped);
        if (interior !== want.inner) report_field("interior", want.inner, interior);
        if (final_re !== want.zr) report_field("final_re", want.zr, final_re);
        if (final_im !== want.zi) report_field("final_im", want.zi, final_im);
        checked++;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, quiet);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    pixel_t want;
    logic [31:0] re, im;
    int unsigned k, p, n, r;
    rst = 1'b1;
    in_valid = 1'b0;
    c_re = '0;
    c_im = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_MAX_ITER;
    cfg_data = '0;
    limit_setting = MAX_ITER_RESET;
    degree_setting = DEGREE_RESET;
    calm = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < NUM_DIRECTED; k++) begin
      if (DIRECTED[k].limit != limit_setting || DIRECTED[k].deg != degree_setting) begin
        drain_pixels();
        program_unit(DIRECTED[k].limit, DIRECTED[k].deg);
      end
      if (DIRECTED[k].known)
        want = '{DIRECTED[k].count, DIRECTED[k].esc, DIRECTED[k].inner,
                 DIRECTED[k].zr, DIRECTED[k].zi};
      else
        want = escape_time_of(DIRECTED[k].re, DIRECTED[k].im);
      send_pixel(DIRECTED[k].re, DIRECTED[k].im, want);
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      drain_pixels();
      program_unit(PHASE_LIMIT[p], PHASE_DEG[p]);
      calm = (p % 5 == 3);
      for (n = 0; n < PIXELS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        if (PHASE_LIMIT[p] > 16'd1000) begin
          // With a huge limit only words that finish at once: the tiny disc around
          // the origin lies inside the cardioid, and far points escape on the first step.
          if (r < 40 && PHASE_DEG[p] <= 3'd2) begin
            re = $signed($urandom) >>> 6;
            im = $signed($urandom) >>> 6;
          end else begin
            re = $urandom;
            im = $urandom;
            if ((re[31:29] == 3'b000 || re[31:29] == 3'b111) &&
                (im[31:29] == 3'b000 || im[31:29] == 3'b111))
              re[30] = ~re[30];
          end
        end else if (r < 60) begin
          re = $signed($urandom) >>> 2;
          im = $signed($urandom) >>> 2;
        end else if (r < 78) begin
          re = ($signed($urandom) >>> 3) - $signed(Q_HALF);
          im = $signed($urandom) >>> 3;
        end else if (r < 90) begin
          re = $urandom;
          im = $urandom;
        end else begin
          re = EDGE_VALUES[$urandom_range(0, 7)];
          im = EDGE_VALUES[$urandom_range(0, 7)];
        end
        send_pixel(re, im, escape_time_of(re, im));
      end
    end

    drain_pixels();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d pixel results, %0d of them from the directed table.",
             checked, NUM_DIRECTED);
    $display("Made %0d register writes over limits 0 to 65535 and degree codes 0 to 7.",
             cfg_writes);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/mbe_pkg.sv
src/mbe_ctrl.sv
src/mbe_dpath.sv
src/multibrot_escape_time_unit.sv
tb/multibrot_escape_time_unit_tb.sv
